// ===== rtl/core/sagq_pkg.sv =====
package sagq_pkg;

  // Field widths
  localparam int IDX_WIDTH  = 24;
  localparam int SUM_WIDTH  = 32;
  localparam int CNT_WIDTH  = 16;
  localparam int BYTE_WIDTH = 8;
  localparam int NUM_CH     = 3;

  // Dividend: the bits of a sum below its sign bit, one quotient bit per divider cell
  localparam int DVD_WIDTH  = SUM_WIDTH - 1;
  localparam int DIV_STEPS  = DVD_WIDTH;
  // Quotients of 2^QUO_WIDTH or more saturate the byte
  localparam int QUO_WIDTH  = 2 * BYTE_WIDTH;
  localparam int ROOT_WIDTH = QUO_WIDTH / 2;
  localparam int SQRT_STEPS = ROOT_WIDTH;
  localparam int REM_WIDTH  = ROOT_WIDTH + 2;

  typedef struct packed {
    logic                  neg;
    logic                  sat;
    logic [CNT_WIDTH-1:0]  rem;
    logic [DVD_WIDTH-1:0]  dvd;
    logic [QUO_WIDTH-1:0]  quo;
  } div_lane_t;

  typedef struct packed {
    logic [IDX_WIDTH-1:0]         idx;
    div_lane_t [NUM_CH-1:0]       lane;
  } div_word_t;

  typedef struct packed {
    logic                  neg;
    logic                  sat;
    logic [QUO_WIDTH-1:0]  rad;
    logic [REM_WIDTH-1:0]  rem;
    logic [ROOT_WIDTH-1:0] root;
  } sqrt_lane_t;

  typedef struct packed {
    logic [IDX_WIDTH-1:0]         idx;
    sqrt_lane_t [NUM_CH-1:0]      lane;
  } sqrt_word_t;

  // Per-cell control: pipeline advance and incoming valid
  typedef struct packed {
    logic adv;
    logic vld;
  } cell_ctl_t;

endpackage

// ===== rtl/core/sample_average_gamma_quantize.sv =====
// Gamma-2 tone map of accumulated RGB pixel sums to three bytes.
// Input channel (in_valid/in_ready): one word per pixel, the buffer offset and
// signed red, green and blue sums. Output channel (out_valid/out_ready): the
// offset and one byte per color, min(255, floor(sqrt(floor(sum / count)))),
// or 0 for a negative sum.
// Config: cfg_wr_en/cfg_wr_data write the sample count (0 acts as 1). Write
// it only while no word is in flight.
// Datapath: a row of 31 divider cells (one quotient bit each) followed by a
// row of 8 square-root cells (one root bit each) and an output register.
// Throughput: one word per cycle while the output does not stall; every cell holds one word in flight.
// Stall: the whole row advances together; when out_valid is high and
// out_ready is low, in_ready drops and all cells hold. in_ready follows
// out_ready combinationally, so a new word is taken in the same cycle the held
// result is taken.
// Reset: clears all valid bits and sets the sample count to 1.
module sample_average_gamma_quantize (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_wr_en,
  input  logic [sagq_pkg::CNT_WIDTH-1:0]         cfg_wr_data,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [sagq_pkg::IDX_WIDTH-1:0]         in_pixel_index,
  input  logic signed [sagq_pkg::SUM_WIDTH-1:0]  in_red_sum,
  input  logic signed [sagq_pkg::SUM_WIDTH-1:0]  in_green_sum,
  input  logic signed [sagq_pkg::SUM_WIDTH-1:0]  in_blue_sum,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [sagq_pkg::IDX_WIDTH-1:0]         out_pixel_index_out,
  output logic [sagq_pkg::BYTE_WIDTH-1:0]        out_red_byte,
  output logic [sagq_pkg::BYTE_WIDTH-1:0]        out_green_byte,
  output logic [sagq_pkg::BYTE_WIDTH-1:0]        out_blue_byte
);

  // Sample count register and effective divisor
  logic [sagq_pkg::CNT_WIDTH-1:0] cnt_r;
  logic [sagq_pkg::CNT_WIDTH-1:0] divisor;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= sagq_pkg::CNT_WIDTH'(1);
    end else if (cfg_wr_en) begin
      cnt_r <= cfg_wr_data;
    end
  end

  assign divisor = (cnt_r == '0) ? sagq_pkg::CNT_WIDTH'(1) : cnt_r;

  // Global advance: the row moves unless a result sits unaccepted
  logic adv;
  logic out_valid_r;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  // Divider row
  logic                 div_vld  [0:sagq_pkg::DIV_STEPS];
  sagq_pkg::div_word_t  div_word [0:sagq_pkg::DIV_STEPS];
  logic [sagq_pkg::SUM_WIDTH-1:0] sum_in [sagq_pkg::NUM_CH];

  assign sum_in[0] = in_red_sum;
  assign sum_in[1] = in_green_sum;
  assign sum_in[2] = in_blue_sum;

  assign div_vld[0]      = in_valid;
  assign div_word[0].idx = in_pixel_index;

  for (genvar g = 0; g < sagq_pkg::NUM_CH; g++) begin : g_in
    assign div_word[0].lane[g].neg = sum_in[g][sagq_pkg::SUM_WIDTH-1];
    assign div_word[0].lane[g].sat = 1'b0;
    assign div_word[0].lane[g].rem = '0;
    assign div_word[0].lane[g].dvd = sum_in[g][sagq_pkg::DVD_WIDTH-1:0];
    assign div_word[0].lane[g].quo = '0;
  end

  for (genvar k = 0; k < sagq_pkg::DIV_STEPS; k++) begin : g_div
    sagq_pkg::cell_ctl_t ctl;
    assign ctl.adv = adv;
    assign ctl.vld = div_vld[k];

    sagq_div_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl_in   (ctl),
      .divisor  (divisor),
      .word_in  (div_word[k]),
      .vld_out  (div_vld[k+1]),
      .word_out (div_word[k+1])
    );
  end

  // Square-root row, fed with the low quotient bits
  logic                 sqrt_vld  [0:sagq_pkg::SQRT_STEPS];
  sagq_pkg::sqrt_word_t sqrt_word [0:sagq_pkg::SQRT_STEPS];

  assign sqrt_vld[0]      = div_vld[sagq_pkg::DIV_STEPS];
  assign sqrt_word[0].idx = div_word[sagq_pkg::DIV_STEPS].idx;

  for (genvar g = 0; g < sagq_pkg::NUM_CH; g++) begin : g_mid
    assign sqrt_word[0].lane[g].neg  = div_word[sagq_pkg::DIV_STEPS].lane[g].neg;
    assign sqrt_word[0].lane[g].sat  = div_word[sagq_pkg::DIV_STEPS].lane[g].sat;
    assign sqrt_word[0].lane[g].rad  = div_word[sagq_pkg::DIV_STEPS].lane[g].quo;
    assign sqrt_word[0].lane[g].rem  = '0;
    assign sqrt_word[0].lane[g].root = '0;
  end

  for (genvar k = 0; k < sagq_pkg::SQRT_STEPS; k++) begin : g_sqrt
    sagq_pkg::cell_ctl_t ctl;
    assign ctl.adv = adv;
    assign ctl.vld = sqrt_vld[k];

    sagq_sqrt_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl_in   (ctl),
      .word_in  (sqrt_word[k]),
      .vld_out  (sqrt_vld[k+1]),
      .word_out (sqrt_word[k+1])
    );
  end

  // Output register: clamp and sign handling
  logic [sagq_pkg::IDX_WIDTH-1:0]  idx_r;
  logic [sagq_pkg::BYTE_WIDTH-1:0] byte_r   [sagq_pkg::NUM_CH];
  logic [sagq_pkg::BYTE_WIDTH-1:0] byte_nxt [sagq_pkg::NUM_CH];

  for (genvar g = 0; g < sagq_pkg::NUM_CH; g++) begin : g_out
    assign byte_nxt[g] = sqrt_word[sagq_pkg::SQRT_STEPS].lane[g].neg ? '0 :
                         sqrt_word[sagq_pkg::SQRT_STEPS].lane[g].sat ? '1 :
                         sqrt_word[sagq_pkg::SQRT_STEPS].lane[g].root;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= sqrt_vld[sagq_pkg::SQRT_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      idx_r <= sqrt_word[sagq_pkg::SQRT_STEPS].idx;
      for (int i = 0; i < sagq_pkg::NUM_CH; i++) begin
        byte_r[i] <= byte_nxt[i];
      end
    end
  end

  assign out_valid           = out_valid_r;
  assign out_pixel_index_out = idx_r;
  assign out_red_byte        = byte_r[0];
  assign out_green_byte      = byte_r[1];
  assign out_blue_byte       = byte_r[2];

  // A held result freezes the whole row; this checks that it drops in_ready
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted while result stalled");

  // Effective divisor is never zero
  a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    divisor != '0)
    else $error("zero divisor");

  // Remainders leaving the divider row stay below the divisor
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    div_vld[sagq_pkg::DIV_STEPS] |->
      (div_word[sagq_pkg::DIV_STEPS].lane[0].rem < divisor) &&
      (div_word[sagq_pkg::DIV_STEPS].lane[1].rem < divisor) &&
      (div_word[sagq_pkg::DIV_STEPS].lane[2].rem < divisor))
    else $error("division remainder out of range");

  // A negative red sum always yields a zero red byte
  a_neg_red_zero: assert property (@(posedge clk) disable iff (!rst_n)
    sqrt_vld[sagq_pkg::SQRT_STEPS] && sqrt_word[sagq_pkg::SQRT_STEPS].lane[0].neg && adv
    |=> out_valid && (out_red_byte == '0))
    else $error("negative sum gave nonzero byte");

endmodule

// ===== rtl/core/sagq_div_cell.sv =====
// One restoring division step per channel: brings down one dividend bit.
module sagq_div_cell (
  input  logic                           clk,
  input  logic                           rst_n,
  input  sagq_pkg::cell_ctl_t            ctl_in,
  input  logic [sagq_pkg::CNT_WIDTH-1:0] divisor,
  input  sagq_pkg::div_word_t            word_in,
  output logic                           vld_out,
  output sagq_pkg::div_word_t            word_out
);

  logic                vld_r;
  sagq_pkg::div_word_t word_r;
  sagq_pkg::div_word_t word_nxt;

  assign word_nxt.idx = word_in.idx;

  for (genvar g = 0; g < sagq_pkg::NUM_CH; g++) begin : g_lane
    logic [sagq_pkg::CNT_WIDTH:0] trial;
    logic [sagq_pkg::CNT_WIDTH:0] diff;
    logic                         ge;

    assign trial = {word_in.lane[g].rem, word_in.lane[g].dvd[sagq_pkg::DVD_WIDTH-1]};
    assign ge    = trial >= {1'b0, divisor};
    assign diff  = trial - {1'b0, divisor};

    assign word_nxt.lane[g].neg = word_in.lane[g].neg;
    // quotient bits leaving the window mean the average is too large and the byte saturates
    assign word_nxt.lane[g].sat = word_in.lane[g].sat |
                                  word_in.lane[g].quo[sagq_pkg::QUO_WIDTH-1];
    assign word_nxt.lane[g].rem = ge ? diff[sagq_pkg::CNT_WIDTH-1:0]
                                     : trial[sagq_pkg::CNT_WIDTH-1:0];
    assign word_nxt.lane[g].dvd = {word_in.lane[g].dvd[sagq_pkg::DVD_WIDTH-2:0], 1'b0};
    assign word_nxt.lane[g].quo = {word_in.lane[g].quo[sagq_pkg::QUO_WIDTH-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ctl_in.adv) begin
      vld_r <= ctl_in.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_in.adv) begin
      word_r <= word_nxt;
    end
  end

  assign vld_out  = vld_r;
  assign word_out = word_r;

endmodule

// ===== rtl/core/sagq_sqrt_cell.sv =====
// One digit-by-digit square root step per channel: resolves one root bit.
module sagq_sqrt_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sagq_pkg::cell_ctl_t  ctl_in,
  input  sagq_pkg::sqrt_word_t word_in,
  output logic                 vld_out,
  output sagq_pkg::sqrt_word_t word_out
);

  logic                 vld_r;
  sagq_pkg::sqrt_word_t word_r;
  sagq_pkg::sqrt_word_t word_nxt;

  assign word_nxt.idx = word_in.idx;

  for (genvar g = 0; g < sagq_pkg::NUM_CH; g++) begin : g_lane
    logic [sagq_pkg::REM_WIDTH+1:0] trial;
    logic [sagq_pkg::REM_WIDTH+1:0] subtr;
    logic [sagq_pkg::REM_WIDTH+1:0] diff;
    logic                           ge;

    assign trial = {word_in.lane[g].rem,
                    word_in.lane[g].rad[sagq_pkg::QUO_WIDTH-1 -: 2]};
    assign subtr = {2'b00, word_in.lane[g].root, 2'b01};
    assign ge    = trial >= subtr;
    assign diff  = trial - subtr;

    assign word_nxt.lane[g].neg  = word_in.lane[g].neg;
    assign word_nxt.lane[g].sat  = word_in.lane[g].sat;
    assign word_nxt.lane[g].rad  = {word_in.lane[g].rad[sagq_pkg::QUO_WIDTH-3:0], 2'b00};
    assign word_nxt.lane[g].rem  = ge ? diff[sagq_pkg::REM_WIDTH-1:0]
                                      : trial[sagq_pkg::REM_WIDTH-1:0];
    assign word_nxt.lane[g].root = {word_in.lane[g].root[sagq_pkg::ROOT_WIDTH-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ctl_in.adv) begin
      vld_r <= ctl_in.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_in.adv) begin
      word_r <= word_nxt;
    end
  end

  assign vld_out  = vld_r;
  assign word_out = word_r;

endmodule
